// ----- design/ptom_pkg.sv -----
// ----------------------------------------------------------------------------
// ptom_pkg: shared definitions for the peer time offset median core
// Widths, window geometry, register indexes, reset values and the types
// that pass between the sequencer, the window stores and the top level.
// ----------------------------------------------------------------------------
package ptom_pkg;

	localparam int TIME_W     = 40;
	localparam int OFF_W      = TIME_W + 1;
	localparam int VAL_W      = 18;
	localparam int NET_W      = 17;
	localparam int ADJ_W      = 42;
	localparam int REJ_W      = 17;
	localparam int CLAMP_W    = 16;
	localparam int MIN_W      = 8;
	localparam int COUNT_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam int WINDOW_DEPTH = 200;
	localparam int IDX_W        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int CMP_W        = (CNT_W > MIN_W) ? CNT_W : MIN_W;

	localparam logic [CFG_IDX_W-1:0] REG_REJECT_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES  = 2'd2;

	localparam logic [REJ_W-1:0]   REJECT_RESET = REJ_W'(24 * 60 * 60);
	localparam logic [CLAMP_W-1:0] CLAMP_RESET  = CLAMP_W'(70 * 60);
	localparam logic [MIN_W-1:0]   MIN_RESET    = MIN_W'(5);

	typedef struct packed {
		logic [REJ_W-1:0]   reject_limit;
		logic [CLAMP_W-1:0] clamp_limit;
		logic [MIN_W-1:0]   min_samples;
	} cfg_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [VAL_W-1:0] wr_data;
	} ram_req_t;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_CHECK    = 8'b0000_0010,
		ST_REMOVE   = 8'b0000_0100,
		ST_INSERT   = 8'b0000_1000,
		ST_INS_ZERO = 8'b0001_0000,
		ST_MEDIAN   = 8'b0010_0000,
		ST_CLAMP    = 8'b0100_0000,
		ST_FINISH   = 8'b1000_0000
	} state_t;

endpackage

// ----- design/ptom_if.sv -----
// ----------------------------------------------------------------------------
// ptom_if: request channels of the peer time offset median core
// Sample channel (peer and local time) and result channel, each with
// valid, ready and payload and a source and a sink modport.
// ----------------------------------------------------------------------------
interface ptom_in_if;
	import ptom_pkg::*;

	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] peer_secs;
	logic [TIME_W-1:0] local_secs;

	modport source (output valid, output peer_secs, output local_secs, input ready);
	modport sink   (input valid, input peer_secs, input local_secs, output ready);
endinterface

interface ptom_out_if;
	import ptom_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    accepted;
	logic signed [NET_W-1:0] time_offset;
	logic [COUNT_W-1:0]      sample_count;
	logic signed [ADJ_W-1:0] adjusted_time;

	modport source (output valid, output accepted, output time_offset,
		output sample_count, output adjusted_time, input ready);
	modport sink   (input valid, input accepted, input time_offset,
		input sample_count, input adjusted_time, output ready);
endinterface

// ----- design/ptom_ram.sv -----
// ----------------------------------------------------------------------------
// ptom_ram: simple dual-port memory
// One write port and one registered read port; a read and a write of the
// same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module ptom_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 18,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

// ----- design/ptom_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptom_ctrl: sequencer and shared compare datapath
// Checks each offset against the reject limit, keeps the arrival ring and
// the sorted window by walking the sorted store one entry per cycle, then
// reads and clamps the median once min_samples are held; registers the result.
// ----------------------------------------------------------------------------
module ptom_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ptom_pkg::cfg_t              cfg,
	ptom_in_if.sink                     samples,
	ptom_out_if.source                  results,
	output ptom_pkg::ram_req_t          ring_req,
	input  logic [ptom_pkg::VAL_W-1:0]  ring_rd_data,
	output ptom_pkg::ram_req_t          srt_req,
	input  logic [ptom_pkg::VAL_W-1:0]  srt_rd_data
);
	import ptom_pkg::*;

	state_t                  state_q;
	logic signed [OFF_W-1:0] off_q;
	logic [TIME_W-1:0]       local_q;
	logic signed [VAL_W-1:0] v_q;
	logic                    accepted_q;
	logic [CNT_W-1:0]        held_q;
	logic [IDX_W-1:0]        oldest_q;
	logic signed [NET_W-1:0] netoff_q;
	logic [CNT_W-1:0]        ia_q;
	logic                    rv_q;
	logic [IDX_W-1:0]        ri_q;
	logic                    found_q;

	logic                    out_valid_q;
	logic                    out_acc_q;
	logic signed [NET_W-1:0] out_off_q;
	logic [COUNT_W-1:0]      out_cnt_q;
	logic signed [ADJ_W-1:0] out_adj_q;

	logic signed [OFF_W-1:0] lim_w;
	logic                    acc_w;
	logic signed [VAL_W-1:0] v_w;
	logic                    full_w;
	logic [CNT_W:0]          ring_sum_w;
	logic [IDX_W-1:0]        ring_wr_addr_w;
	logic [IDX_W-1:0]        oldest_next_w;
	logic signed [VAL_W-1:0] rd_val_w;
	logic                    match_w;
	logic                    gt_w;
	logic [IDX_W-1:0]        last_w;
	logic                    med_go_w;
	logic signed [VAL_W-1:0] climit_w;
	logic signed [VAL_W-1:0] clamp_w;
	logic signed [ADJ_W-1:0] adj_w;
	logic                    load_w;

	assign lim_w  = $signed({{(OFF_W - REJ_W){1'b0}}, cfg.reject_limit});
	assign acc_w  = (off_q <= lim_w) && (off_q >= -lim_w);
	assign v_w    = off_q[VAL_W-1:0];
	assign full_w = (held_q == CNT_W'(WINDOW_DEPTH));

	assign ring_sum_w     = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(held_q);
	assign ring_wr_addr_w = (ring_sum_w >= (CNT_W + 1)'(WINDOW_DEPTH))
		? IDX_W'(ring_sum_w - (CNT_W + 1)'(WINDOW_DEPTH)) : IDX_W'(ring_sum_w);
	assign oldest_next_w  = (oldest_q == IDX_W'(WINDOW_DEPTH - 1))
		? '0 : IDX_W'(oldest_q + 1'b1);

	// The compare logic: the word just read from the sorted store
	// against the leaving offset or against the new offset.
	assign rd_val_w = $signed(srt_rd_data);
	assign match_w  = (srt_rd_data == ring_rd_data);
	assign gt_w     = (rd_val_w > v_q);
	assign last_w   = IDX_W'(held_q - 1'b1);

	assign med_go_w = (CMP_W'(held_q) >= CMP_W'(cfg.min_samples));
	assign climit_w = $signed({{(VAL_W - CLAMP_W){1'b0}}, cfg.clamp_limit});
	assign clamp_w  = (rd_val_w > climit_w) ? climit_w
		: ((rd_val_w < -climit_w) ? -climit_w : rd_val_w);
	assign adj_w    = $signed({{(ADJ_W - TIME_W){1'b0}}, local_q}) + ADJ_W'(netoff_q);
	assign load_w   = (state_q == ST_FINISH) && (!out_valid_q || results.ready);

	assign samples.ready         = (state_q == ST_IDLE);
	assign results.valid         = out_valid_q;
	assign results.accepted      = out_acc_q;
	assign results.time_offset   = out_off_q;
	assign results.sample_count  = out_cnt_q;
	assign results.adjusted_time = out_adj_q;

	always_comb begin
		ring_req = '0;
		srt_req  = '0;
		unique case (state_q)
			ST_CHECK: begin
				if (acc_w) begin
					ring_req.wr_en   = 1'b1;
					ring_req.wr_data = v_w;
					if (full_w) begin
						// Fetch the leaving offset while its slot takes the new one.
						ring_req.rd_en   = 1'b1;
						ring_req.rd_addr = oldest_q;
						ring_req.wr_addr = oldest_q;
					end else begin
						ring_req.wr_addr = ring_wr_addr_w;
					end
				end
			end
			ST_REMOVE: begin
				if (ia_q < held_q) begin
					srt_req.rd_en   = 1'b1;
					srt_req.rd_addr = ia_q[IDX_W-1:0];
				end
				if (rv_q && found_q) begin
					srt_req.wr_en   = 1'b1;
					srt_req.wr_addr = IDX_W'(ri_q - 1'b1);
					srt_req.wr_data = srt_rd_data;
				end
			end
			ST_INSERT: begin
				if (ia_q != '0) begin
					srt_req.rd_en   = 1'b1;
					srt_req.rd_addr = IDX_W'(ia_q - 1'b1);
				end
				if (rv_q) begin
					srt_req.wr_en   = 1'b1;
					srt_req.wr_addr = IDX_W'(ri_q + 1'b1);
					srt_req.wr_data = gt_w ? srt_rd_data : v_q;
				end
			end
			ST_INS_ZERO: begin
				srt_req.wr_en   = 1'b1;
				srt_req.wr_addr = '0;
				srt_req.wr_data = v_q;
			end
			ST_MEDIAN: begin
				if (med_go_w) begin
					srt_req.rd_en   = 1'b1;
					srt_req.rd_addr = IDX_W'(held_q >> 1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			off_q       <= '0;
			local_q     <= '0;
			v_q         <= '0;
			accepted_q  <= 1'b0;
			held_q      <= '0;
			oldest_q    <= '0;
			netoff_q    <= '0;
			ia_q        <= '0;
			rv_q        <= 1'b0;
			ri_q        <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_acc_q   <= 1'b0;
			out_off_q   <= '0;
			out_cnt_q   <= '0;
			out_adj_q   <= '0;
		end else begin
			if (out_valid_q && results.ready && !load_w) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						off_q   <= $signed({1'b0, samples.peer_secs})
							- $signed({1'b0, samples.local_secs});
						local_q <= samples.local_secs;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					accepted_q <= acc_w;
					v_q        <= v_w;
					rv_q       <= 1'b0;
					found_q    <= 1'b0;
					if (!acc_w) begin
						state_q <= ST_FINISH;
					end else if (full_w) begin
						oldest_q <= oldest_next_w;
						ia_q     <= '0;
						state_q  <= ST_REMOVE;
					end else if (held_q == '0) begin
						state_q <= ST_INS_ZERO;
					end else begin
						ia_q    <= held_q;
						state_q <= ST_INSERT;
					end
				end
				ST_REMOVE: begin
					// Reads stream upward; entries above the match move down one.
					if (ia_q < held_q) begin
						ia_q <= CNT_W'(ia_q + 1'b1);
						ri_q <= ia_q[IDX_W-1:0];
						rv_q <= 1'b1;
					end else begin
						rv_q <= 1'b0;
					end
					if (rv_q) begin
						if (!found_q && match_w) begin
							found_q <= 1'b1;
						end
						if (ri_q == last_w) begin
							held_q  <= CNT_W'(held_q - 1'b1);
							ia_q    <= CNT_W'(held_q - 1'b1);
							rv_q    <= 1'b0;
							state_q <= ST_INSERT;
						end
					end
				end
				ST_INSERT: begin
					// Reads stream downward; larger entries move up one until
					// the new offset finds its place.
					if (ia_q != '0) begin
						ia_q <= CNT_W'(ia_q - 1'b1);
						ri_q <= IDX_W'(ia_q - 1'b1);
						rv_q <= 1'b1;
					end else begin
						rv_q <= 1'b0;
					end
					if (rv_q) begin
						if (gt_w) begin
							if (ri_q == '0) begin
								rv_q    <= 1'b0;
								state_q <= ST_INS_ZERO;
							end
						end else begin
							held_q  <= CNT_W'(held_q + 1'b1);
							rv_q    <= 1'b0;
							state_q <= ST_MEDIAN;
						end
					end
				end
				ST_INS_ZERO: begin
					held_q  <= CNT_W'(held_q + 1'b1);
					state_q <= ST_MEDIAN;
				end
				ST_MEDIAN: begin
					state_q <= med_go_w ? ST_CLAMP : ST_FINISH;
				end
				ST_CLAMP: begin
					netoff_q <= NET_W'(clamp_w);
					state_q  <= ST_FINISH;
				end
				ST_FINISH: begin
					if (load_w) begin
						out_valid_q <= 1'b1;
						out_acc_q   <= accepted_q;
						out_off_q   <= netoff_q;
						out_cnt_q   <= COUNT_W'(held_q);
						out_adj_q   <= adj_w;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/peer_time_offset_median_core.sv -----
// ----------------------------------------------------------------------------
// peer_time_offset_median_core: network time offset from peer samples
// Rejects outlying peer offsets, keeps a window of recent offsets in
// arrival order and in sorted order, and tracks the clamped median.
//
//   channel   direction  payload
//   samples   sink       peer_secs, local_secs
//   results   source     accepted, time_offset, sample_count, adjusted_time
//   cfg       write      cfg_we, cfg_index, cfg_data
//
// A rejected sample passes from request to result through the check and
// finish states. An accepted one also takes the downward insertion walk
// of the sorted store while the window holds fewer than 200 offsets,
// and once full a removal walk over the sorted store comes first; the single
// read port of the sorted store paces these walks. No new sample is taken
// while one is in work; a finished result waits in the output register.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module peer_time_offset_median_core (
	input  logic                             clk,
	input  logic                             arst_n,
	ptom_in_if.sink                          samples,
	ptom_out_if.source                       results,
	input  logic                             cfg_we,
	input  logic [ptom_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ptom_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ptom_pkg::*;

	cfg_t             cfg_q;
	ram_req_t         ring_req;
	ram_req_t         srt_req;
	logic [VAL_W-1:0] ring_rd_data;
	logic [VAL_W-1:0] srt_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reject_limit <= REJECT_RESET;
			cfg_q.clamp_limit  <= CLAMP_RESET;
			cfg_q.min_samples  <= MIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REJECT_LIMIT: cfg_q.reject_limit <= cfg_data[REJ_W-1:0];
				REG_CLAMP_LIMIT:  cfg_q.clamp_limit  <= cfg_data[CLAMP_W-1:0];
				REG_MIN_SAMPLES:  cfg_q.min_samples  <= cfg_data[MIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ptom_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(VAL_W)) u_ring (
		.clk     (clk),
		.rd_en   (ring_req.rd_en),
		.rd_addr (ring_req.rd_addr),
		.rd_data (ring_rd_data),
		.wr_en   (ring_req.wr_en),
		.wr_addr (ring_req.wr_addr),
		.wr_data (ring_req.wr_data)
	);

	ptom_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(VAL_W)) u_sorted (
		.clk     (clk),
		.rd_en   (srt_req.rd_en),
		.rd_addr (srt_req.rd_addr),
		.rd_data (srt_rd_data),
		.wr_en   (srt_req.wr_en),
		.wr_addr (srt_req.wr_addr),
		.wr_data (srt_req.wr_data)
	);

	ptom_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.samples      (samples),
		.results      (results),
		.ring_req     (ring_req),
		.ring_rd_data (ring_rd_data),
		.srt_req      (srt_req),
		.srt_rd_data  (srt_rd_data)
	);

endmodule
